/* rtl/fts_pkg.sv */
package fts_pkg;

    typedef struct packed {
        logic        opcode;
        logic [31:0] effect_us;
        logic [31:0] show_us;
        logic [31:0] serial_us;
        logic [31:0] network_us;
        logic [31:0] total_us;
        logic [31:0] free_heap;
        logic [31:0] max_free_block;
    } fts_in_t;

    typedef struct packed {
        logic [31:0] avg_total_us;
        logic [31:0] avg_effect_us;
        logic [31:0] avg_show_us;
        logic [31:0] idle_us;
        logic [31:0] peak_total_us;
        logic [31:0] dropped_count;
        logic [31:0] frame_count;
        logic [6:0]  cpu_percent;
        logic [6:0]  fragmentation_percent;
        logic [31:0] min_free_heap;
        logic        history_written;
        logic [7:0]  fps_sample;
    } fts_out_t;

    localparam int DIVIDEND_W = 71;
    localparam int DIVISOR_W  = 64;
    localparam int QUOT_W     = 8;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } fts_div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } fts_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMA,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_CLEAR
    } fts_state_t;

    typedef enum logic [1:0] {
        DIV_CPU,
        DIV_FRAG,
        DIV_FPS
    } fts_div_sel_t;

    localparam logic       CFG_TARGET    = 1'b0;
    localparam logic       CFG_WEIGHT    = 1'b1;
    localparam logic       OP_FRAME      = 1'b0;
    localparam logic       OP_CLEAR      = 1'b1;
    localparam logic [19:0] TARGET_RESET = 20'd16666;
    localparam logic [15:0] WEIGHT_RESET = 16'd6554;
    localparam logic [16:0] EMA_ONE      = 17'h10000;
    localparam logic [19:0] FPS_NUM      = 20'd1000000;
    localparam logic [31:0] FPS_SAT_AVG  = 32'd3906;
    localparam logic [7:0]  FPS_MAX      = 8'd255;
    localparam logic [6:0]  PCT_FULL     = 7'd100;
    localparam logic [3:0]  DIV_STEPS    = 4'd8;
    localparam logic [2:0]  AVG_EFFECT   = 3'd0;
    localparam logic [2:0]  AVG_SHOW     = 3'd1;
    localparam logic [2:0]  AVG_SERIAL   = 3'd2;
    localparam logic [2:0]  AVG_NETWORK  = 3'd3;
    localparam logic [2:0]  AVG_TOTAL    = 3'd4;
    localparam logic [2:0]  AVG_IDLE     = 3'd5;

endpackage

/* rtl/fts_div.sv */
module fts_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fts_pkg::fts_div_req_t req,
    output fts_pkg::fts_div_rsp_t rsp
);
    import fts_pkg::*;

    logic [DIVIDEND_W:0]  rem_reg, rem_next;
    logic [DIVIDEND_W:0]  den_reg, den_next;
    logic [QUOT_W-1:0]    q_reg, q_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.dividend};
            den_next  = {req.divisor, 7'b0, 1'b0} >> 1;
            q_next    = '0;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= den_reg)
            begin
                rem_next = rem_reg - den_reg;
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUOT_W-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

/* rtl/frame_timing_statistics.sv */
// A frame report runs the six averages through the EMA state, then up to three divisions
// (CPU, fragmentation, FPS) before its result is loaded; a statistics reset takes at most the FPS one.
// A new item is taken only once the last result is loaded; in_stall stays high until the result is loaded.
// The shared 32x17 multiplier forms each average in a product phase and an accumulate phase.
// The serial divider yields one quotient bit per step. Reset clears counters, totals, averages
// and peaks, then clears the history ring entry by entry with in_stall high.
module frame_timing_statistics #(
    parameter int HISTORY_DEPTH    = 64,
    parameter int HISTORY_INTERVAL = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fts_pkg::fts_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output fts_pkg::fts_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [19:0]       cfg_data
);
    import fts_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int RES_W = (HISTORY_INTERVAL > 1) ? $clog2(HISTORY_INTERVAL) : 1;

    fts_state_t   state_reg, state_next;
    fts_div_sel_t sel_reg, sel_next;
    logic [19:0]  target_reg, target_next;
    logic [15:0]  weight_reg, weight_next;
    logic [31:0]  frame_reg, frame_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic [31:0]  dropped_reg, dropped_next;
    logic [63:0]  tsum_reg, tsum_next;
    logic [63:0]  asum_reg, asum_next;
    logic [31:0]  avg_reg [6];
    logic [31:0]  avg_next [6];
    logic [31:0]  peak_reg [5];
    logic [31:0]  peak_next [5];
    logic [31:0]  minheap_reg, minheap_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [6:0]   cpu_reg, cpu_next;
    logic         ovalid_reg, ovalid_next;
    logic [2:0]   idx_reg, idx_next;
    logic         phase_reg, phase_next;

    fts_in_t      in_reg, in_next;
    logic [31:0]  idle_reg, idle_next;
    logic         hist_reg, hist_next;
    logic [6:0]   frag_reg, frag_next;
    logic [7:0]   fps_reg, fps_next;
    logic [48:0]  prod_reg, prod_next;
    fts_out_t     out_reg, out_next;

    logic [14:0]  ring_mem [HISTORY_DEPTH];
    logic         ring_we;
    logic [14:0]  ring_wdata;

    fts_div_req_t div_req;
    fts_div_rsp_t div_rsp;

    logic [33:0]  active;
    logic [21:0]  tri_target;
    logic [31:0]  frame_inc;
    logic [31:0]  sample;
    logic [31:0]  mul_a;
    logic [16:0]  mul_b;
    logic [48:0]  mul_p;
    logic [49:0]  acc;

    fts_div ud (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    always_comb
    begin
        case (idx_reg)
            AVG_EFFECT:  sample = in_reg.effect_us;
            AVG_SHOW:    sample = in_reg.show_us;
            AVG_SERIAL:  sample = in_reg.serial_us;
            AVG_NETWORK: sample = in_reg.network_us;
            AVG_TOTAL:   sample = in_reg.total_us;
            default:     sample = idle_reg;
        endcase
        mul_a = phase_reg ? sample : avg_reg[idx_reg];
        mul_b = phase_reg ? {1'b0, weight_reg} : (EMA_ONE - {1'b0, weight_reg});
        mul_p = 49'(mul_a) * 49'(mul_b);
        acc   = {1'b0, prod_reg} + {1'b0, mul_p};
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        target_next  = target_reg;
        weight_next  = weight_reg;
        frame_next   = frame_reg;
        res_next     = res_reg;
        dropped_next = dropped_reg;
        tsum_next    = tsum_reg;
        asum_next    = asum_reg;
        avg_next     = avg_reg;
        peak_next    = peak_reg;
        minheap_next = minheap_reg;
        ptr_next     = ptr_reg;
        cpu_next     = cpu_reg;
        ovalid_next  = ovalid_reg;
        idx_next     = idx_reg;
        phase_next   = phase_reg;
        in_next      = in_reg;
        idle_next    = idle_reg;
        hist_next    = hist_reg;
        frag_next    = frag_reg;
        fps_next     = fps_reg;
        prod_next    = prod_reg;
        out_next     = out_reg;
        ring_we      = 1'b0;
        ring_wdata   = {fps_reg, cpu_reg};
        div_req      = '0;

        active = 34'(in_data.effect_us) + 34'(in_data.show_us)
               + 34'(in_data.serial_us) + 34'(in_data.network_us);
        tri_target = {2'b0, target_reg} + {1'b0, target_reg, 1'b0};
        frame_inc  = frame_reg + 32'd1;

        if (cfg_we)
        begin
            if (cfg_index == CFG_TARGET)
            begin
                target_next = cfg_data;
            end
            else
            begin
                weight_next = cfg_data[15:0];
            end
        end

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ring_we    = 1'b1;
                ring_wdata = '0;
                if (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next = in_data;
                    if (in_data.opcode == OP_CLEAR)
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            peak_next[i] = '0;
                        end
                        dropped_next = '0;
                        minheap_next = in_data.free_heap;
                        tsum_next    = '0;
                        asum_next    = '0;
                        idle_next    = '0;
                        frag_next    = '0;
                        hist_next    = 1'b0;
                        sel_next     = DIV_FPS;
                        state_next   = ST_DIV_START;
                    end
                    else
                    begin
                        frame_next = frame_inc;
                        if (frame_inc == 32'd0)
                        begin
                            res_next = '0;
                        end
                        else if (res_reg == RES_W'(HISTORY_INTERVAL - 1))
                        begin
                            res_next = '0;
                        end
                        else
                        begin
                            res_next = res_reg + RES_W'(1);
                        end
                        hist_next = (res_next == '0);
                        idle_next = (34'(in_data.total_us) > active)
                                  ? 32'(34'(in_data.total_us) - active) : 32'd0;
                        if (in_data.total_us > 32'(tri_target[21:1]))
                        begin
                            dropped_next = dropped_reg + 32'd1;
                        end
                        if (in_data.effect_us > peak_reg[0])  peak_next[0] = in_data.effect_us;
                        if (in_data.show_us > peak_reg[1])    peak_next[1] = in_data.show_us;
                        if (in_data.serial_us > peak_reg[2])  peak_next[2] = in_data.serial_us;
                        if (in_data.network_us > peak_reg[3]) peak_next[3] = in_data.network_us;
                        if (in_data.total_us > peak_reg[4])   peak_next[4] = in_data.total_us;
                        tsum_next = tsum_reg + 64'(in_data.total_us);
                        asum_next = asum_reg + 64'(active);
                        if (in_data.free_heap < minheap_reg)
                        begin
                            minheap_next = in_data.free_heap;
                        end
                        idx_next   = '0;
                        phase_next = 1'b0;
                        state_next = ST_EMA;
                    end
                end
            end
            ST_EMA:
            begin
                if (!phase_reg)
                begin
                    prod_next  = mul_p;
                    phase_next = 1'b1;
                end
                else
                begin
                    avg_next[idx_reg] = acc[47:16];
                    phase_next = 1'b0;
                    if (idx_reg == AVG_IDLE)
                    begin
                        sel_next   = DIV_CPU;
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_DIV_START:
            begin
                case (sel_reg)
                    DIV_CPU:
                    begin
                        sel_next = DIV_FRAG;
                        if (tsum_reg != 64'd0)
                        begin
                            if (asum_reg >= tsum_reg)
                            begin
                                cpu_next = PCT_FULL;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {asum_reg, 7'b0} - {2'b0, asum_reg, 5'b0}
                                                 + {5'b0, asum_reg, 2'b0};
                                div_req.divisor  = tsum_reg;
                                sel_next   = DIV_CPU;
                                state_next = ST_DIV_WAIT;
                            end
                        end
                    end
                    DIV_FRAG:
                    begin
                        sel_next = DIV_FPS;
                        if (in_reg.free_heap == 32'd0
                            || in_reg.max_free_block >= in_reg.free_heap)
                        begin
                            frag_next = '0;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = 71'({in_reg.max_free_block, 6'b0})
                                             + 71'({in_reg.max_free_block, 5'b0})
                                             + 71'({in_reg.max_free_block, 2'b0});
                            div_req.divisor  = 64'(in_reg.free_heap);
                            sel_next   = DIV_FRAG;
                            state_next = ST_DIV_WAIT;
                        end
                    end
                    default:
                    begin
                        if (avg_reg[AVG_TOTAL] == 32'd0)
                        begin
                            fps_next   = '0;
                            state_next = ST_FINISH;
                        end
                        else if (avg_reg[AVG_TOTAL] <= FPS_SAT_AVG)
                        begin
                            fps_next   = FPS_MAX;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = 71'(FPS_NUM);
                            div_req.divisor  = 64'(avg_reg[AVG_TOTAL]);
                            state_next = ST_DIV_WAIT;
                        end
                    end
                endcase
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (sel_reg)
                        DIV_CPU:
                        begin
                            cpu_next   = div_rsp.quotient[6:0];
                            sel_next   = DIV_FRAG;
                            state_next = ST_DIV_START;
                        end
                        DIV_FRAG:
                        begin
                            frag_next  = PCT_FULL - div_rsp.quotient[6:0];
                            sel_next   = DIV_FPS;
                            state_next = ST_DIV_START;
                        end
                        default:
                        begin
                            fps_next   = div_rsp.quotient;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    out_next.avg_total_us          = avg_reg[AVG_TOTAL];
                    out_next.avg_effect_us         = avg_reg[AVG_EFFECT];
                    out_next.avg_show_us           = avg_reg[AVG_SHOW];
                    out_next.idle_us               = idle_reg;
                    out_next.peak_total_us         = peak_reg[4];
                    out_next.dropped_count         = dropped_reg;
                    out_next.frame_count           = frame_reg;
                    out_next.cpu_percent           = cpu_reg;
                    out_next.fragmentation_percent = frag_reg;
                    out_next.min_free_heap         = minheap_reg;
                    out_next.history_written       = hist_reg;
                    out_next.fps_sample            = fps_reg;
                    ovalid_next = 1'b1;
                    if (hist_reg)
                    begin
                        ring_we  = 1'b1;
                        ptr_next = (ptr_reg == PTR_W'(HISTORY_DEPTH - 1))
                                 ? '0 : ptr_reg + PTR_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            sel_reg     <= DIV_CPU;
            target_reg  <= TARGET_RESET;
            weight_reg  <= WEIGHT_RESET;
            frame_reg   <= '0;
            res_reg     <= '0;
            dropped_reg <= '0;
            tsum_reg    <= '0;
            asum_reg    <= '0;
            for (int i = 0; i < 6; i++)
            begin
                avg_reg[i] <= '0;
            end
            for (int i = 0; i < 5; i++)
            begin
                peak_reg[i] <= '0;
            end
            minheap_reg <= '1;
            ptr_reg     <= '0;
            cpu_reg     <= '0;
            ovalid_reg  <= 1'b0;
            idx_reg     <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            target_reg  <= target_next;
            weight_reg  <= weight_next;
            frame_reg   <= frame_next;
            res_reg     <= res_next;
            dropped_reg <= dropped_next;
            tsum_reg    <= tsum_next;
            asum_reg    <= asum_next;
            avg_reg     <= avg_next;
            peak_reg    <= peak_next;
            minheap_reg <= minheap_next;
            ptr_reg     <= ptr_next;
            cpu_reg     <= cpu_next;
            ovalid_reg  <= ovalid_next;
            idx_reg     <= idx_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        idle_reg <= idle_next;
        hist_reg <= hist_next;
        frag_reg <= frag_next;
        fps_reg  <= fps_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
        if (ring_we)
        begin
            ring_mem[ptr_reg] <= ring_wdata;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/fts_chk.sv */
module fts_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input fts_pkg::fts_out_t out_data
);
    import fts_pkg::*;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.cpu_percent <= PCT_FULL
                      && out_data.fragmentation_percent <= PCT_FULL)
        else $error("percent out of range");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result carries unknown bits");

endmodule

bind frame_timing_statistics fts_chk u_fts_chk (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import fts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS = 175;

    typedef struct {
        fts_in_t  item;
        bit       chk;
        fts_out_t res;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    fts_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    fts_out_t out_data;
    logic     cfg_we;
    logic     cfg_index;
    logic [19:0] cfg_data;

    logic [19:0] target_us;
    logic [15:0] weight_q16;
    logic [31:0] frames_seen;
    logic [31:0] dropped_frames;
    logic [63:0] total_sum;
    logic [63:0] active_sum;
    logic [31:0] avg_times [6];
    logic [31:0] peak_times [5];
    logic [31:0] least_heap;
    logic [6:0]  last_cpu;

    fts_out_t stats_q[$];
    dir_row_t dir_rows[16];
    int       cycles;
    int       errors;
    int       reported;
    int       transfers_in;
    int       transfers_out;
    int       clears_sent;
    int       history_writes;
    int       hold_cycles;
    bit       hold_done;

    frame_timing_statistics dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] ema(logic [31:0] old, logic [31:0] sample);
        logic [63:0] acc;
        acc = 64'(old) * (64'd65536 - 64'(weight_q16)) + 64'(sample) * 64'(weight_q16);
        return acc[47:16];
    endfunction

    function automatic logic [7:0] fps_of_avg();
        logic [31:0] f;
        if (avg_times[AVG_TOTAL] == 0)
            return 8'd0;
        f = 32'd1000000 / avg_times[AVG_TOTAL];
        return (f > 255) ? FPS_MAX : f[7:0];
    endfunction

    function automatic fts_out_t update_stats(fts_in_t it);
        fts_out_t    r;
        logic [33:0] active;
        logic [63:0] limit;
        logic [31:0] idle;
        logic [70:0] quot;
        logic [6:0]  frag;
        bit          written;
        idle = 0;
        frag = 0;
        written = 0;
        if (it.opcode == OP_CLEAR)
        begin
            foreach (peak_times[i]) peak_times[i] = 0;
            dropped_frames = 0;
            least_heap = it.free_heap;
            total_sum = 0;
            active_sum = 0;
        end
        else
        begin
            active = 34'(it.effect_us) + 34'(it.show_us) + 34'(it.serial_us)
                     + 34'(it.network_us);
            limit = (64'(target_us) * 3) / 2;
            frames_seen = frames_seen + 1;
            if (34'(it.total_us) > active)
                idle = it.total_us - active[31:0];
            if (64'(it.total_us) > limit)
                dropped_frames = dropped_frames + 1;
            avg_times[AVG_EFFECT]  = ema(avg_times[AVG_EFFECT], it.effect_us);
            avg_times[AVG_SHOW]    = ema(avg_times[AVG_SHOW], it.show_us);
            avg_times[AVG_SERIAL]  = ema(avg_times[AVG_SERIAL], it.serial_us);
            avg_times[AVG_NETWORK] = ema(avg_times[AVG_NETWORK], it.network_us);
            avg_times[AVG_TOTAL]   = ema(avg_times[AVG_TOTAL], it.total_us);
            avg_times[AVG_IDLE]    = ema(avg_times[AVG_IDLE], idle);
            if (it.effect_us > peak_times[0]) peak_times[0] = it.effect_us;
            if (it.show_us > peak_times[1]) peak_times[1] = it.show_us;
            if (it.serial_us > peak_times[2]) peak_times[2] = it.serial_us;
            if (it.network_us > peak_times[3]) peak_times[3] = it.network_us;
            if (it.total_us > peak_times[4]) peak_times[4] = it.total_us;
            total_sum = total_sum + 64'(it.total_us);
            active_sum = active_sum + 64'(active);
            if (total_sum != 0)
            begin
                if (active_sum >= total_sum)
                    last_cpu = PCT_FULL;
                else
                begin
                    quot = (71'(active_sum) * 71'd100) / 71'(total_sum);
                    last_cpu = quot[6:0];
                end
            end
            if (it.free_heap < least_heap)
                least_heap = it.free_heap;
            if (it.free_heap != 0)
            begin
                quot = (71'(it.max_free_block) * 71'd100) / 71'(it.free_heap);
                frag = (quot >= 100) ? 7'd0 : 7'(100 - quot);
            end
            if (frames_seen % 10 == 0)
                written = 1;
        end
        r.avg_total_us = avg_times[AVG_TOTAL];
        r.avg_effect_us = avg_times[AVG_EFFECT];
        r.avg_show_us = avg_times[AVG_SHOW];
        r.idle_us = idle;
        r.peak_total_us = peak_times[4];
        r.dropped_count = dropped_frames;
        r.frame_count = frames_seen;
        r.cpu_percent = last_cpu;
        r.fragmentation_percent = frag;
        r.min_free_heap = least_heap;
        r.history_written = written;
        r.fps_sample = fps_of_avg();
        return r;
    endfunction

    task automatic field_check(string name, logic [31:0] want, logic [31:0] got,
                               inout bit bad);
        if (want !== got)
        begin
            bad = 1;
            if (reported < 10)
                $display("mismatch at result %0d: %s expected %0h got %0h",
                         transfers_out, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        fts_out_t want;
        bit       bad;
        if (rst_n && out_valid && !out_stall)
        begin
            bad = 0;
            if (stats_q.size() == 0)
            begin
                errors = errors + 1;
                if (reported < 10)
                    $display("unexpected result at cycle %0d", cycles);
                reported = reported + 1;
            end
            else
            begin
                want = stats_q.pop_front();
                field_check("avg_total_us", want.avg_total_us, out_data.avg_total_us, bad);
                field_check("avg_effect_us", want.avg_effect_us, out_data.avg_effect_us, bad);
                field_check("avg_show_us", want.avg_show_us, out_data.avg_show_us, bad);
                field_check("idle_us", want.idle_us, out_data.idle_us, bad);
                field_check("peak_total_us", want.peak_total_us, out_data.peak_total_us, bad);
                field_check("dropped_count", want.dropped_count, out_data.dropped_count, bad);
                field_check("frame_count", want.frame_count, out_data.frame_count, bad);
                field_check("cpu_percent", want.cpu_percent, out_data.cpu_percent, bad);
                field_check("fragmentation_percent", want.fragmentation_percent,
                            out_data.fragmentation_percent, bad);
                field_check("min_free_heap", want.min_free_heap, out_data.min_free_heap, bad);
                field_check("history_written", want.history_written,
                            out_data.history_written, bad);
                field_check("fps_sample", want.fps_sample, out_data.fps_sample, bad);
                if (want.history_written)
                    history_writes = history_writes + 1;
                if (bad)
                begin
                    errors = errors + 1;
                    reported = reported + 1;
                end
            end
            transfers_out = transfers_out + 1;
        end
    end

    // receiver: random stalls and hold-offs, one long hold-off once the run is under way
    always @(negedge clk)
    begin
        int r;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && transfers_in >= 400)
        begin
            hold_done = 1;
            hold_cycles = 400;
            out_stall <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (transfers_in % 200 < 40)
                out_stall <= 1'b0;
            else if (r < 3)
                hold_cycles = $urandom_range(20, 80);
            else
                out_stall <= (r < 30);
        end
    end

    task automatic send_item(fts_in_t it, bit use_row, fts_out_t row_res);
        int gap;
        fts_out_t pred;
        int r;
        r = $urandom_range(0, 99);
        if (transfers_in % 200 >= 160)
            gap = 0;
        else if (r < 60)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pred = update_stats(it);
        stats_q.push_back(use_row ? row_res : pred);
        transfers_in = transfers_in + 1;
        if (it.opcode == OP_CLEAR)
            clears_sent = clears_sent + 1;
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [19:0] value);
        in_valid <= 1'b0;
        wait (stats_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TARGET)
            target_us = value;
        else
            weight_q16 = value[15:0];
    endtask

    function automatic logic [31:0] pick_time(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom();
        else if (r == 1)
            return $urandom_range(0, 3000);
        return $urandom_range(0, span);
    endfunction

    function automatic fts_in_t random_item();
        fts_in_t it;
        int span;
        span = (target_us == 0) ? 100 : 2 * target_us;
        it.opcode = ($urandom_range(0, 99) < 8) ? OP_CLEAR : OP_FRAME;
        it.total_us = pick_time(span);
        it.effect_us = pick_time(span / 3 + 1);
        it.show_us = pick_time(span / 4 + 1);
        it.serial_us = pick_time(span / 8 + 1);
        it.network_us = pick_time(span / 8 + 1);
        if ($urandom_range(0, 3) == 0)
        begin
            it.free_heap = $urandom();
            it.max_free_block = $urandom();
        end
        else
        begin
            it.free_heap = $urandom_range(0, 300000);
            it.max_free_block = $urandom_range(0, it.free_heap + 1000);
        end
        return it;
    endfunction

    initial
    begin
        logic [19:0] targets [6];
        logic [15:0] weights [6];
        fts_out_t none;
        none = '0;
        targets = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd33333, 20'd16666};
        weights = '{16'd65535, 16'd1, 16'd0, 16'hFFFF, 16'd32768, 16'd6554};

        dir_rows[0] = '{fts_in_t'{OP_FRAME, 0, 0, 0, 0, 0, 0, 0}, 1,
                        fts_out_t'{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0}};
        dir_rows[1] = '{fts_in_t'{OP_CLEAR, 0, 0, 0, 0, 0, 5, 0}, 1,
                        fts_out_t'{0, 0, 0, 0, 0, 0, 1, 0, 0, 5, 0, 0}};
        dir_rows[2] = '{fts_in_t'{OP_FRAME, '1, '1, '1, '1, '1, '1, '1}, 0, none};
        dir_rows[3] = '{fts_in_t'{OP_FRAME, 0, 0, 0, 0, '1, 1, 0}, 0, none};
        dir_rows[4] = '{fts_in_t'{OP_FRAME, 10, 20, 30, 40, 50, 100, 200}, 0, none};
        dir_rows[5] = '{fts_in_t'{OP_CLEAR, 7, 7, 7, 7, 7, '1, 7}, 0, none};
        for (int i = 6; i < 16; i++)
            dir_rows[i] = '{fts_in_t'{OP_FRAME, 4000, 6000, 500, 500, 16000 + 1000 * i,
                                      200000, 100000}, 0, none};

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TARGET;
        cfg_data = '0;
        cycles = 0;
        errors = 0;
        reported = 0;
        transfers_in = 0;
        transfers_out = 0;
        clears_sent = 0;
        history_writes = 0;
        hold_cycles = 0;
        hold_done = 0;
        target_us = TARGET_RESET;
        weight_q16 = WEIGHT_RESET;
        frames_seen = 0;
        dropped_frames = 0;
        total_sum = 0;
        active_sum = 0;
        foreach (avg_times[i]) avg_times[i] = 0;
        foreach (peak_times[i]) peak_times[i] = 0;
        least_heap = '1;
        last_cpu = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res);

        foreach (targets[p])
        begin
            write_reg(CFG_TARGET, targets[p]);
            write_reg(CFG_WEIGHT, 20'(weights[p]));
            repeat (PHASE_ITEMS) send_item(random_item(), 0, none);
        end
        in_valid <= 1'b0;
        wait (stats_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d transfers in, %0d results, %0d statistics clears,",
                 transfers_in, transfers_out, clears_sent);
        $display("%0d history writes over 7 register settings, %0d mismatches",
                 history_writes, errors);
        if (errors == 0 && stats_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
